// File: rtl/core/swa_pkg.sv
// Shared types and constants for the sliding-window average block.
// No dependencies; used by swa_div and sliding_window_average.
`default_nettype none

package swa_pkg;

  localparam int AVG_WIDTH = 24;
  localparam int LEN_WIDTH = 7;
  localparam logic [LEN_WIDTH-1:0] LEN_RESET = 7'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV
  } swa_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } swa_div_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/swa_div.sv
// Bit-serial signed divider: (sum * 2^FRAC_BITS) / divisor, truncated toward zero,
// saturated to the average width. Depends on swa_pkg.
`default_nettype none

module swa_div #(
  parameter int SUM_W     = 22,
  parameter int FRAC_BITS = 8,
  parameter int DIV_W     = 7
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  input  wire logic signed [SUM_W-1:0]         dividend,
  input  wire logic [DIV_W-1:0]                divisor,
  output swa_pkg::swa_div_stat_t               stat,
  output logic signed [swa_pkg::AVG_WIDTH-1:0] quotient
);

  localparam int NW  = SUM_W + FRAC_BITS;
  localparam int CW  = $clog2(NW + 1);
  localparam int EW  = (NW > swa_pkg::AVG_WIDTH) ? NW : swa_pkg::AVG_WIDTH;
  localparam int AW  = swa_pkg::AVG_WIDTH;

  logic [NW-1:0]    qd_r, qd_nxt;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W:0]   rem_nxt;
  logic [DIV_W-1:0] d_r;
  logic             neg_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;

  logic [SUM_W-1:0] mag;
  logic [DIV_W:0]   rem_sh;
  logic             ge;
  logic [EW-1:0]    q_ext;

  assign mag = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

  always_comb begin
    rem_sh  = {rem_r, qd_r[NW-1]};
    ge      = (rem_sh >= {1'b0, d_r});
    rem_nxt = ge ? (rem_sh - {1'b0, d_r}) : rem_sh;
    qd_nxt  = {qd_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // The dividend shifts out of the top while quotient bits enter at the bottom.
  // The remainder stays below the divisor, so its top bit is always clear.
  always_ff @(posedge clk) begin
    if (start) begin
      qd_r  <= {mag, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      d_r   <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      qd_r  <= qd_nxt;
      rem_r <= rem_nxt[DIV_W-1:0];
    end
  end

  assign q_ext = EW'(qd_r);

  always_comb begin
    if (neg_r) begin
      if (q_ext > EW'(2 ** (AW - 1))) quotient = {1'b1, {(AW - 1){1'b0}}};
      else                            quotient = -$signed(q_ext[AW-1:0]);
    end else begin
      if (q_ext > EW'(2 ** (AW - 1) - 1)) quotient = {1'b0, {(AW - 1){1'b1}}};
      else                                quotient = $signed(q_ext[AW-1:0]);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// File: rtl/core/sliding_window_average.sv
// Top level of the sliding-window average block: delay-line memory, running sum,
// control sequencer and output register. Depends on swa_pkg and swa_div.
`default_nettype none

// Moving average over the last window_len samples of a signed stream, one word in
// and at most one word out. Samples sit in a single-port-read memory of WINDOW_MAX
// entries; the running sum is updated by read-modify-write of the oldest entry.
// A sample that yields no result (window not yet full) occupies the block for the
// accepting cycle, which issues the memory read, and the update cycle.
// A sample that yields a result goes on from the update cycle to the divide state,
// where the one-bit-per-cycle divider forms sum * 2^FRAC_BITS / window_len; the
// average then loads into the output register. The output register lets the next
// sample be taken while a finished average waits. A window_len of 0 acts as 1, any
// value above WINDOW_MAX as WINDOW_MAX, and any write to it empties the window.
module sliding_window_average #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 8
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_wr_en,
  input  wire logic [swa_pkg::LEN_WIDTH-1:0]     cfg_wr_data,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  input  wire                                    in_first,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic signed [swa_pkg::AVG_WIDTH-1:0]   out_average
);

  localparam int LW0    = $clog2(WINDOW_MAX + 1);
  localparam int LW     = (LW0 > swa_pkg::LEN_WIDTH) ? LW0 : swa_pkg::LEN_WIDTH;
  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(WINDOW_MAX);

  swa_pkg::swa_state_t state_r, state_nxt;

  logic [swa_pkg::LEN_WIDTH-1:0] window_len_r;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic [LW-1:0]                 fill_r, fill_nxt;
  logic [SLOT_W-1:0]             slot_r, slot_nxt;
  logic signed [SAMPLE_WIDTH-1:0] s_r;

  logic [SAMPLE_WIDTH-1:0] mem [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] rdata_r;

  logic signed [swa_pkg::AVG_WIDTH-1:0] out_average_r;
  logic                                 out_valid_r;

  logic [LW-1:0]       wl, len_act;
  logic                accept;
  logic [SLOT_W-1:0]   slot_base, slot_eff;
  logic signed [SUM_W-1:0] old_ext;
  logic                result_due;
  logic                div_start;
  logic                out_load;

  swa_pkg::swa_div_stat_t              div_stat;
  logic signed [swa_pkg::AVG_WIDTH-1:0] div_q;

  always_comb begin
    wl = LW'(window_len_r);
    if (wl == '0)                  len_act = LW'(1);
    else if (wl > LW'(WINDOW_MAX)) len_act = LW'(WINDOW_MAX);
    else                           len_act = wl;
  end

  assign accept = in_valid && !in_stall;

  // Write slot after the first flag has been applied and wrapped into the active window.
  always_comb begin
    slot_base = in_first ? '0 : slot_r;
    slot_eff  = (LW'(slot_base) >= len_act) ? '0 : slot_base;
  end

  // Update of the running sum with the entry that leaves the window, and of the fill count and write slot.
  always_comb begin
    old_ext  = (fill_r >= len_act) ? SUM_W'(rdata_r) : '0;
    sum_nxt  = sum_r - old_ext + SUM_W'(s_r);
    fill_nxt = (fill_r < len_act) ? fill_r + 1'b1 : fill_r;
    slot_nxt = (LW'(slot_r) + LW'(1) >= len_act) ? '0 : slot_r + SLOT_W'(1);
    result_due = (fill_nxt >= len_act);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swa_pkg::ST_IDLE: if (accept) state_nxt = swa_pkg::ST_UPD;
      swa_pkg::ST_UPD:  state_nxt = result_due ? swa_pkg::ST_DIV : swa_pkg::ST_IDLE;
      swa_pkg::ST_DIV:  if (out_load) state_nxt = swa_pkg::ST_IDLE;
      default:          state_nxt = swa_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      swa_pkg::ST_IDLE: in_stall = 1'b0;
      swa_pkg::ST_UPD:  div_start = result_due;
      swa_pkg::ST_DIV:  out_load = div_stat.done && (!out_valid_r || !out_stall);
      default:          in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= swa_pkg::ST_IDLE;
      window_len_r <= swa_pkg::LEN_RESET;
      sum_r        <= '0;
      fill_r       <= '0;
      slot_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        window_len_r <= cfg_wr_data;
        sum_r        <= '0;
        fill_r       <= '0;
        slot_r       <= '0;
      end else if (accept) begin
        if (in_first) begin
          sum_r  <= '0;
          fill_r <= '0;
        end
        slot_r <= slot_eff;
      end else if (state_r == swa_pkg::ST_UPD) begin
        sum_r  <= sum_nxt;
        fill_r <= fill_nxt;
        slot_r <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s_r <= in_sample;
  end

  // The write lands in the update cycle, before any later read can be issued.
  always_ff @(posedge clk) begin
    if (state_r == swa_pkg::ST_UPD) mem[slot_r] <= s_r;
    if (accept) rdata_r <= mem[slot_eff];
  end

  swa_div #(
    .SUM_W     (SUM_W),
    .FRAC_BITS (FRAC_BITS),
    .DIV_W     (LW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (len_act),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_average_r <= div_q;
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swa_pkg::ST_IDLE) |-> (fill_r <= len_act))
    else $error("window fill count exceeds window length");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swa_pkg::ST_UPD) |-> (LW'(slot_r) < len_act))
    else $error("write slot outside the active ring");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !div_stat.busy)
    else $error("sample accepted while the divider is busy");

  a_load_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_stat.done && !out_load)
    else $error("average loaded before the divider finished");
`endif

endmodule

`default_nettype wire
